[rtl/tdlr_pkg.sv]
package tdlr_pkg;

   // Lane and field widths of one word pair and of one result
   localparam int LANES      = 64;
   localparam int WORD_W     = LANES;
   localparam int PC_W       = $clog2(LANES + 1);
   localparam int COUNT_W    = 19;
   localparam int DOT_W      = 20;
   localparam int OUT_W      = 35;
   localparam int ALPHA_W    = 16;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 4 * WORD_W;
   localparam int RSP_DATA_W = ((DOT_W + OUT_W + 7) / 8) * 8;

   // Parameter defaults
   localparam int MAX_WORDS_DEF = 4096;
   localparam int FRAC_BITS_DEF = 14;

   // Finished dot product on its way to the activation stage
   typedef struct packed {
      logic             valid;
      logic [DOT_W-1:0] dot;
   } dot_beat_type;

   // Count the set lanes of one word
   function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] word);
      logic [PC_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + PC_W'(word[i]);
      end
      return n;
   endfunction

endpackage

[rtl/tdlr_count.sv]
module tdlr_count
   import tdlr_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [WORD_W-1:0]     act_sign,
   input  logic [WORD_W-1:0]     act_mask,
   input  logic [WORD_W-1:0]     ker_sign,
   input  logic [WORD_W-1:0]     ker_mask,
   input  logic                  last_word,
   output dot_beat_type          dot_beat,
   input  logic                  dot_ready
);

   localparam int CapRaw     = MAX_WORDS * LANES;
   localparam int CountLimit = (2 ** COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] CountCap =
      COUNT_W'((CapRaw < CountLimit) ? CapRaw : CountLimit);

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff, s1_last_in;
   logic [WORD_W-1:0]   both_ff, both_in;
   logic [WORD_W-1:0]   neg_ff, neg_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  negc_ff, negc_in;
   logic                dot_valid_ff, dot_valid_in;
   logic [DOT_W-1:0]    dot_ff, dot_in;

   logic                s1_go;
   logic [COUNT_W:0]    total_sum, negc_sum;
   logic [COUNT_W-1:0]  total_sat, negc_sat;
   logic [DOT_W:0]      dot_wide;

   // A plain word always moves on; a last word needs room in the dot stage
   assign s1_go    = s1_valid_ff && (!s1_last_ff || !dot_valid_ff || dot_ready);
   assign in_ready = !s1_valid_ff || s1_go;

   // Reduce the beat to the lanes that count and the lanes that are negative
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      both_in     = both_ff;
      neg_in      = neg_ff;
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
         s1_last_in  = last_word;
         both_in     = act_mask & ker_mask;
         neg_in      = (act_sign ^ ker_sign) & act_mask & ker_mask;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Accumulate with saturation, form the dot product, clear on a last word
   always_comb begin
      total_sum = {1'b0, total_ff} + (COUNT_W + 1)'(popcount(both_ff));
      negc_sum  = {1'b0, negc_ff} + (COUNT_W + 1)'(popcount(neg_ff));
      total_sat = (total_sum > {1'b0, CountCap}) ? CountCap : total_sum[COUNT_W-1:0];
      negc_sat  = (negc_sum > {1'b0, CountCap}) ? CountCap : negc_sum[COUNT_W-1:0];
      dot_wide  = {2'b00, total_sat} - {1'b0, negc_sat, 1'b0};

      total_in     = total_ff;
      negc_in      = negc_ff;
      dot_in       = dot_ff;
      dot_valid_in = dot_valid_ff;
      if (dot_ready) begin
         dot_valid_in = 1'b0;
      end
      if (s1_go) begin
         if (s1_last_ff) begin
            total_in     = '0;
            negc_in      = '0;
            dot_in       = dot_wide[DOT_W-1:0];
            dot_valid_in = 1'b1;
         end else begin
            total_in = total_sat;
            negc_in  = negc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         total_ff     <= '0;
         negc_ff      <= '0;
         dot_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         total_ff     <= total_in;
         negc_ff      <= negc_in;
         dot_valid_ff <= dot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      both_ff <= both_in;
      neg_ff  <= neg_in;
      dot_ff  <= dot_in;
   end

   assign dot_beat.valid = dot_valid_ff;
   assign dot_beat.dot   = dot_ff;

endmodule

[rtl/tdlr_act.sv]
module tdlr_act
   import tdlr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dot_beat_type         dot_beat,
   output logic                 dot_ready,
   input  logic [ALPHA_W-1:0]   alpha_q14,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DOT_W-1:0]     dot_value,
   output logic [OUT_W-1:0]     out_value
);

   localparam int RawW = ((FRAC_BITS > ALPHA_W) ? (DOT_W + FRAC_BITS) : (DOT_W + ALPHA_W)) + 1;
   localparam logic signed [RawW-1:0] OutMax = RawW'({1'b0, {(OUT_W - 1){1'b1}}});
   localparam logic signed [RawW-1:0] OutMin = ~OutMax;

   logic                              out_valid_ff, out_valid_in;
   logic [DOT_W-1:0]                  dot_ff, dot_in;
   logic [OUT_W-1:0]                  value_ff, value_in;

   logic signed [DOT_W-1:0]           dot_s;
   logic signed [ALPHA_W-1:0]         alpha_s;
   logic signed [DOT_W+ALPHA_W-1:0]   prod;
   logic signed [RawW-1:0]            shifted;
   logic signed [RawW-1:0]            raw;
   logic signed [RawW-1:0]            sat;

   assign dot_ready = !out_valid_ff || out_ready;

   // Positive dot scales up by the fraction width; the rest takes the slope
   always_comb begin
      dot_s   = $signed(dot_beat.dot);
      alpha_s = $signed(alpha_q14);
      prod    = dot_s * alpha_s;
      shifted = RawW'(dot_s) <<< FRAC_BITS;
      raw     = (dot_s > 0) ? shifted : RawW'(prod);
      if (raw > OutMax) begin
         sat = OutMax;
      end else if (raw < OutMin) begin
         sat = OutMin;
      end else begin
         sat = raw;
      end
   end

   // Hold the result until the sink takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      dot_in       = dot_ff;
      value_in     = value_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (dot_beat.valid && dot_ready) begin
         out_valid_in = 1'b1;
         dot_in       = dot_beat.dot;
         value_in     = sat[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dot_ff   <= dot_in;
      value_ff <= value_in;
   end

   assign out_valid = out_valid_ff;
   assign dot_value = dot_ff;
   assign out_value = value_ff;

endmodule

[rtl/ternary_dot_leaky_relu.sv]
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------------
// req       | in        | req_tvalid/tready   | tdata: act_sign, act_mask, ker_sign, ker_mask
//           |           |                     | tlast: last_word
// rsp       | out       | rsp_tvalid/tready   | tdata: dot_value, out_value, zero pad
// csr       | in        | csr_we              | csr_wdata: alpha_q14
//
// One word pair is taken every cycle unless a last word waits in the input register.
// A tlast beat passes the input register, the count and dot register, and the result register.
// The popcount and saturating accumulate of a word pair are combinational.
// Reset clears the counts, alpha and all valid flags.
// A stalled result holds the result register; the stages behind it keep
// taking beats until their registers fill. A plain word in the input register
// never waits, but a last word there waits for room in the dot register.
module ternary_dot_leaky_relu
   import tdlr_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // act_sign, act_mask, ker_sign, ker_mask
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // dot_value, out_value, zero pad
   input  logic                   csr_we,
   input  logic [ALPHA_W-1:0]     csr_wdata
);

   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   dot_beat_type       dot_beat;
   logic               dot_ready;
   logic [DOT_W-1:0]   dot_value;
   logic [OUT_W-1:0]   out_value;

   // Latch the slope on a write
   assign alpha_in = csr_we ? csr_wdata : alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   tdlr_count #(
      .MAX_WORDS (MAX_WORDS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .act_sign  (req_tdata[WORD_W-1:0]),
      .act_mask  (req_tdata[2*WORD_W-1:WORD_W]),
      .ker_sign  (req_tdata[3*WORD_W-1:2*WORD_W]),
      .ker_mask  (req_tdata[4*WORD_W-1:3*WORD_W]),
      .last_word (req_tlast),
      .dot_beat  (dot_beat),
      .dot_ready (dot_ready)
   );

   tdlr_act #(
      .FRAC_BITS (FRAC_BITS)
   ) u_act (
      .clock     (clock),
      .reset     (reset),
      .dot_beat  (dot_beat),
      .dot_ready (dot_ready),
      .alpha_q14 (alpha_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dot_value (dot_value),
      .out_value (out_value)
   );

   assign rsp_tdata = {{(RSP_DATA_W - DOT_W - OUT_W){1'b0}}, out_value, dot_value};

endmodule

[rtl/tdlr_checker.sv]
module tdlr_checker
   import tdlr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic signed [DOT_W-1:0] dot_s;
   logic [OUT_W-1:0]        val;

   assign dot_s = $signed(rsp_tdata[DOT_W-1:0]);
   assign val   = rsp_tdata[DOT_W+OUT_W-1:DOT_W];

   // No result survives a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A positive dot passes as a positive value
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (dot_s > 0) |-> !val[OUT_W-1] && (val != '0))
      else $error("positive dot gave a non-positive value");

   // A zero dot gives zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (dot_s == 0) |-> (val == '0))
      else $error("zero dot gave a nonzero value");

endmodule

bind ternary_dot_leaky_relu tdlr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
